### rtl/abs_pkg.sv
package abs_pkg;

   localparam int OUT_BITS = 39;
   localparam int PEN_BITS = 10;
   localparam int ADDR_BITS = 3;
   localparam int COUNT_BITS = 4;

   localparam logic [0:0] REG_GAP_OPEN = 1'b0;
   localparam logic [0:0] REG_GAP_EXTEND = 1'b1;

   localparam logic [PEN_BITS-1:0] GAP_OPEN_RESET = 10'd400;
   localparam logic [PEN_BITS-1:0] GAP_EXTEND_RESET = 10'd30;

   localparam logic [2:0] CODE_A = 3'd0;
   localparam logic [2:0] CODE_C = 3'd1;
   localparam logic [2:0] CODE_G = 3'd2;
   localparam logic [2:0] CODE_T = 3'd3;
   localparam logic [2:0] CODE_AMB = 3'd4;
   localparam logic [2:0] CODE_GAP = 3'd5;

   typedef struct packed {
      logic [63:0] column_chars;
      logic [3:0]  seq_count;
      logic        first_column;
      logic        last_column;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] block_score;
      logic                       saturated;
   } rsp_type;

   typedef struct packed {
      logic                step;
      logic                active;
      logic                clear;
      logic [2:0]          ref_code;
      logic [2:0]          code;
      logic [PEN_BITS-1:0] gap_open;
      logic [PEN_BITS-1:0] gap_extend;
   } abs_lane_ctl_type;

   typedef struct packed {
      logic                  go;
      logic [COUNT_BITS-1:0] count;
   } abs_merge_start_type;

   typedef struct packed {
      logic idle;
      logic done;
   } abs_merge_status_type;

   function automatic logic [2:0] char_code(input logic [7:0] ch);
      logic [2:0] code;
      case (ch)
         "A", "a":           code = CODE_A;
         "C", "c":           code = CODE_C;
         "G", "g":           code = CODE_G;
         "T", "t", "U", "u": code = CODE_T;
         "-":                code = CODE_GAP;
         default:            code = CODE_AMB;
      endcase
      return code;
   endfunction

   // hoxd70 substitution, zero for anything ambiguous
   function automatic logic signed [7:0] hoxd70(input logic [2:0] r, input logic [2:0] c);
      logic signed [7:0] v;
      case ({r, c})
         {CODE_A, CODE_A}: v = 8'sd91;
         {CODE_A, CODE_C}: v = -8'sd114;
         {CODE_A, CODE_G}: v = -8'sd31;
         {CODE_A, CODE_T}: v = -8'sd123;
         {CODE_C, CODE_A}: v = -8'sd114;
         {CODE_C, CODE_C}: v = 8'sd100;
         {CODE_C, CODE_G}: v = -8'sd125;
         {CODE_C, CODE_T}: v = -8'sd31;
         {CODE_G, CODE_A}: v = -8'sd31;
         {CODE_G, CODE_C}: v = -8'sd125;
         {CODE_G, CODE_G}: v = 8'sd100;
         {CODE_G, CODE_T}: v = -8'sd114;
         {CODE_T, CODE_A}: v = -8'sd123;
         {CODE_T, CODE_C}: v = -8'sd31;
         {CODE_T, CODE_G}: v = -8'sd114;
         {CODE_T, CODE_T}: v = 8'sd91;
         default:          v = 8'sd0;
      endcase
      return v;
   endfunction

   function automatic logic [6:0] ref_bonus(input logic [2:0] r);
      logic [6:0] v;
      case (r)
         CODE_A:  v = 7'd91;
         CODE_C:  v = 7'd100;
         CODE_G:  v = 7'd100;
         CODE_T:  v = 7'd91;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/abs_lane.sv
module abs_lane
   import abs_pkg::*;
#(
   parameter int SCORE_BITS = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  abs_lane_ctl_type             ctl,
   output logic signed [SCORE_BITS-1:0] score,
   output logic                         clip
);

   localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
   localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

   logic signed [SCORE_BITS-1:0] score_ff, score_in;
   logic                         closed_ff, closed_in;

   logic signed [SCORE_BITS-1:0] base_score;
   logic                         base_closed;
   logic                         gap;
   logic [PEN_BITS-1:0]          pen;
   logic signed [11:0]           delta;
   logic signed [SCORE_BITS:0]   sum;
   logic                         ovf;
   logic signed [SCORE_BITS-1:0] sat;

   always_comb begin
      base_score  = ctl.clear ? '0 : score_ff;
      base_closed = ctl.clear | closed_ff;
      gap         = (ctl.code == CODE_GAP) || (ctl.ref_code == CODE_GAP);
      pen         = base_closed ? ctl.gap_open : ctl.gap_extend;
      delta       = gap ? -$signed({2'b00, pen}) : 12'(hoxd70(ctl.ref_code, ctl.code));
      sum         = {base_score[SCORE_BITS-1], base_score} + (SCORE_BITS+1)'(delta);
      ovf         = sum[SCORE_BITS] != sum[SCORE_BITS-1];
      sat         = ovf ? (sum[SCORE_BITS] ? SCORE_MIN : SCORE_MAX) : sum[SCORE_BITS-1:0];

      score_in  = score_ff;
      closed_in = closed_ff;
      if (ctl.step) begin
         if (ctl.active) begin
            score_in  = sat;
            closed_in = !gap;
         end else if (ctl.clear) begin
            score_in  = '0;
            closed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff  <= '0;
         closed_ff <= 1'b1;
      end else begin
         score_ff  <= score_in;
         closed_ff <= closed_in;
      end
   end

   assign score = score_ff;
   assign clip  = ctl.step & ctl.active & ovf;

endmodule

### rtl/abs_merge.sv
module abs_merge
   import abs_pkg::*;
#(
   parameter int MAX_SEQS   = 8,
   parameter int SCORE_BITS = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  abs_merge_start_type          start,
   input  logic signed [SCORE_BITS-1:0] bonus,
   input  logic signed [SCORE_BITS-1:0] lane_score [MAX_SEQS],
   input  logic                         take,
   output abs_merge_status_type         status,
   output logic signed [OUT_BITS-1:0]   score,
   output logic                         clip
);

   localparam int IW    = $clog2(MAX_SEQS);
   localparam int AW    = SCORE_BITS + 3;
   localparam int RW    = SCORE_BITS + 12;
   localparam int MW    = SCORE_BITS + 11;
   localparam int CNT_W = $clog2(MW + 1);
   localparam int CW    = ((RW > OUT_BITS) ? RW : OUT_BITS) + 1;

   localparam logic signed [CW-1:0] OUT_MAX_X =
      {{(CW-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [CW-1:0] OUT_MIN_X = ~OUT_MAX_X;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic signed [AW-1:0]  acc_ff, acc_in;
   logic [3:0]            rem_ff, rem_in;
   logic [MW-1:0]         quo_ff, quo_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic signed [AW-1:0] total;
   logic                 sum_last;
   logic signed [RW-1:0] dividend;
   logic [RW-1:0]        mag;
   logic [4:0]           trial;
   logic                 ge;
   logic signed [RW-1:0] res;
   logic signed [CW-1:0] res_x;

   always_comb begin
      total    = acc_ff + AW'(lane_score[idx_ff]);
      sum_last = COUNT_BITS'(idx_ff) == (count_ff - COUNT_BITS'(1));
      // the value is scaled by 256 before the divide
      if (count_ff >= COUNT_BITS'(2)) begin
         dividend = RW'(total) <<< 8;
      end else begin
         dividend = RW'(bonus) <<< 8;
      end
      mag   = dividend[RW-1] ? RW'(-dividend) : RW'(dividend);
      trial = {rem_ff, quo_ff[MW-1]};
      ge    = trial >= {1'b0, count_ff};

      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start.go) begin
               state_in = ST_SUM;
               count_in = start.count;
               idx_in   = '0;
               acc_in   = '0;
            end
         end
         ST_SUM: begin
            acc_in = total;
            idx_in = idx_ff + IW'(1);
            if (sum_last) begin
               state_in = ST_DIV;
               quo_in   = mag[MW-1:0];
               neg_in   = dividend[RW-1];
               rem_in   = '0;
               cnt_in   = CNT_W'(MW);
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in = ge ? 4'(trial - {1'b0, count_ff}) : trial[3:0];
            quo_in = {quo_ff[MW-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
   end

   always_comb begin
      res   = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      res_x = CW'(res);
      if (res_x > OUT_MAX_X) begin
         score = OUT_MAX_X[OUT_BITS-1:0];
         clip  = 1'b1;
      end else if (res_x < OUT_MIN_X) begin
         score = OUT_MIN_X[OUT_BITS-1:0];
         clip  = 1'b1;
      end else begin
         score = res_x[OUT_BITS-1:0];
         clip  = 1'b0;
      end
   end

   assign status.idle = state_ff == ST_IDLE;
   assign status.done = state_ff == ST_OUT;

endmodule

### rtl/alignment_block_scorer.sv
// Alignment block scorer: HOXD70 substitution scores with affine gap costs.
// Columns arrive on the req_ channel, one column word per handshake; byte k
// of column_chars is sequence k, byte 0 the reference. One lane per
// sequence keeps that sequence's running score and gap-run flag.
// Columns without last_column are taken one per cycle while the merge is idle.
// A column with last_column starts the merge: a lane-by-lane sum over the n
// sequences, a bit-serial divide by n and a load of the output register;
// the score then appears on the rsp_ channel. req_ready stays low while the
// merge runs.
// A finished result sits in the rsp_ register until taken; while the
// receiver stalls, new columns are still taken, and the next block's result
// waits in the merge until the register is free.
// Gap penalties are written through the csr_ port, at byte addresses 0 and 4.
// Reset clears all lane scores, the reference bonus sum and the clip flag,
// marks every gap run closed and restores penalties 400 and 30.
module alignment_block_scorer
   import abs_pkg::*;
#(
   parameter int MAX_SEQS   = 8,
   parameter int SCORE_BITS = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_word,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
   localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

   logic [PEN_BITS-1:0]          gap_open_ff, gap_open_in;
   logic [PEN_BITS-1:0]          gap_extend_ff, gap_extend_in;
   logic signed [SCORE_BITS-1:0] bonus_ff, bonus_in;
   logic                         clip_seen_ff, clip_seen_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   logic                         csr_write;
   logic [0:0]                   csr_index;
   logic                         accept;
   logic [COUNT_BITS-1:0]        n;
   logic [2:0]                   ref_code;
   logic signed [SCORE_BITS-1:0] bonus_base;
   logic signed [SCORE_BITS:0]   bonus_sum;
   logic                         bonus_ovf;
   logic [MAX_SEQS-1:0]          lane_clip;
   logic signed [SCORE_BITS-1:0] lane_score [MAX_SEQS];
   abs_lane_ctl_type             lane_ctl [MAX_SEQS];
   abs_merge_start_type          merge_start;
   abs_merge_status_type         merge_status;
   logic signed [OUT_BITS-1:0]   merge_score;
   logic                         merge_clip;
   logic                         slot_free;
   logic                         take;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[ADDR_BITS-1:2];

   always_comb begin
      gap_open_in   = gap_open_ff;
      gap_extend_in = gap_extend_ff;
      if (csr_write) begin
         case (csr_index)
            REG_GAP_OPEN:   gap_open_in   = csr_pwdata[PEN_BITS-1:0];
            REG_GAP_EXTEND: gap_extend_in = csr_pwdata[PEN_BITS-1:0];
            default:        gap_open_in   = gap_open_ff;
         endcase
      end
      case (csr_index)
         REG_GAP_OPEN:   csr_prdata = 32'(gap_open_ff);
         REG_GAP_EXTEND: csr_prdata = 32'(gap_extend_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // column intake
   assign req_ready = merge_status.idle;
   assign accept    = req_valid && req_ready;
   assign ref_code  = char_code(req_word.column_chars[7:0]);

   always_comb begin
      if (req_word.seq_count == '0) begin
         n = COUNT_BITS'(1);
      end else if (req_word.seq_count > COUNT_BITS'(MAX_SEQS)) begin
         n = COUNT_BITS'(MAX_SEQS);
      end else begin
         n = req_word.seq_count;
      end
   end

   genvar k;
   generate
      for (k = 0; k < MAX_SEQS; k++) begin : g_lane
         assign lane_ctl[k].step       = accept;
         assign lane_ctl[k].active     = COUNT_BITS'(k) < n;
         assign lane_ctl[k].clear      = req_word.first_column;
         assign lane_ctl[k].ref_code   = ref_code;
         assign lane_ctl[k].code       = char_code(req_word.column_chars[8*k +: 8]);
         assign lane_ctl[k].gap_open   = gap_open_ff;
         assign lane_ctl[k].gap_extend = gap_extend_ff;

         abs_lane #(
            .SCORE_BITS(SCORE_BITS)
         ) u_lane (
            .clock (clock),
            .reset (reset),
            .ctl   (lane_ctl[k]),
            .score (lane_score[k]),
            .clip  (lane_clip[k])
         );
      end
   endgenerate

   // reference bonus sum, used when the block has a single sequence
   always_comb begin
      bonus_base = req_word.first_column ? '0 : bonus_ff;
      bonus_sum  = {bonus_base[SCORE_BITS-1], bonus_base}
                 + (SCORE_BITS+1)'(ref_bonus(ref_code));
      bonus_ovf  = bonus_sum[SCORE_BITS] != bonus_sum[SCORE_BITS-1];
   end

   assign merge_start.go    = accept && req_word.last_column;
   assign merge_start.count = n;

   abs_merge #(
      .MAX_SEQS   (MAX_SEQS),
      .SCORE_BITS (SCORE_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .start      (merge_start),
      .bonus      (bonus_ff),
      .lane_score (lane_score),
      .take       (take),
      .status     (merge_status),
      .score      (merge_score),
      .clip       (merge_clip)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign take      = merge_status.done && slot_free;

   always_comb begin
      bonus_in     = bonus_ff;
      clip_seen_in = clip_seen_ff;
      if (accept) begin
         if (bonus_ovf) begin
            bonus_in = bonus_sum[SCORE_BITS] ? SCORE_MIN : SCORE_MAX;
         end else begin
            bonus_in = bonus_sum[SCORE_BITS-1:0];
         end
         clip_seen_in = (!req_word.first_column && clip_seen_ff) || bonus_ovf || (|lane_clip);
      end else if (take) begin
         clip_seen_in = clip_seen_ff || merge_clip;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_valid_in          = 1'b1;
         rsp_in.block_score    = merge_score;
         rsp_in.saturated      = clip_seen_ff || merge_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_open_ff   <= GAP_OPEN_RESET;
         gap_extend_ff <= GAP_EXTEND_RESET;
         bonus_ff      <= '0;
         clip_seen_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gap_open_ff   <= gap_open_in;
         gap_extend_ff <= gap_extend_in;
         bonus_ff      <= bonus_in;
         clip_seen_ff  <= clip_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_last_starts_merge: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.last_column) |=> !req_ready)
      else $error("last column did not start the merge");

   a_result_after_merge: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> !$past(req_ready))
      else $error("result word without a finished merge");

   a_clip_sticky: assert property (@(posedge clock) disable iff (reset)
      (clip_seen_ff && !(accept && req_word.first_column)) |=> clip_seen_ff)
      else $error("clip flag dropped inside a block");
`endif

endmodule

### sim/testbench.sv
module testbench
   import abs_pkg::*;
();

   localparam int MAX_LANES = 8;
   localparam int SCORE_BITS = 31;
   localparam int DRAIN_CYCLES = 64;
   localparam int IDLE_PCT = 11;
   localparam int RANDOM_ITEMS = 2000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_word;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_word;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   // scoring state kept alongside the block
   longint              lane_score [MAX_LANES];
   bit                  lane_run_closed [MAX_LANES];
   longint              bonus_total;
   bit                  clip_flag;
   logic [PEN_BITS-1:0] open_pen;
   logic [PEN_BITS-1:0] extend_pen;

   int hoxd70_score [0:3][0:3] = '{
      '{  91, -114,  -31, -123},
      '{-114,  100, -125,  -31},
      '{ -31, -125,  100, -114},
      '{-123,  -31, -114,   91}
   };

   rsp_type expected_scores [$];
   int      error_count;
   int      columns_sent;
   bit      no_idle;
   int      hold_request;
   int      hold_left;

   alignment_block_scorer #(
      .MAX_SEQS   (MAX_LANES),
      .SCORE_BITS (SCORE_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("testbench failed");
      $finish;
   end

   // receiver: random stalls, or a long hold-off counted here
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scores.size() == 0) begin
            $error("result word with no score expected");
            error_count++;
         end else begin
            want = expected_scores.pop_front();
            if (rsp_word.block_score !== want.block_score) begin
               $error("block_score expected %0d actual %0d",
                      want.block_score, rsp_word.block_score);
               error_count++;
            end
            if (rsp_word.saturated !== want.saturated) begin
               $error("saturated expected %0d actual %0d", want.saturated, rsp_word.saturated);
               error_count++;
            end
         end
      end
   end

   function automatic logic [2:0] base_code(logic [7:0] ch);
      if (ch == "A" || ch == "a") return CODE_A;
      if (ch == "C" || ch == "c") return CODE_C;
      if (ch == "G" || ch == "g") return CODE_G;
      if (ch == "T" || ch == "t" || ch == "U" || ch == "u") return CODE_T;
      if (ch == "-") return CODE_GAP;
      return CODE_AMB;
   endfunction

   function automatic int pair_score(logic [2:0] r, logic [2:0] c);
      if (r > CODE_T || c > CODE_T) return 0;
      return hoxd70_score[r][c];
   endfunction

   function automatic int column_bonus(logic [2:0] r);
      if (r == CODE_A || r == CODE_T) return 91;
      if (r == CODE_C || r == CODE_G) return 100;
      return 0;
   endfunction

   function longint clamp_score(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         clip_flag = 1'b1;
         return hi;
      end
      if (v < lo) begin
         clip_flag = 1'b1;
         return lo;
      end
      return v;
   endfunction

   task automatic score_column(req_type w);
      int          n;
      logic [2:0]  r;
      logic [2:0]  c;
      longint      pen;
      longint      total;
      rsp_type     e;
      n = w.seq_count;
      if (n == 0) n = 1;
      if (n > MAX_LANES) n = MAX_LANES;
      if (w.first_column) begin
         for (int k = 0; k < MAX_LANES; k++) begin
            lane_score[k] = 0;
            lane_run_closed[k] = 1'b1;
         end
         bonus_total = 0;
         clip_flag = 1'b0;
      end
      r = base_code(w.column_chars[7:0]);
      bonus_total = clamp_score(bonus_total + column_bonus(r), SCORE_BITS);
      for (int k = 0; k < n; k++) begin
         c = base_code(w.column_chars[8*k +: 8]);
         if (c == CODE_GAP || r == CODE_GAP) begin
            pen = lane_run_closed[k] ? longint'(open_pen) : longint'(extend_pen);
            lane_run_closed[k] = 1'b0;
            lane_score[k] = clamp_score(lane_score[k] - pen, SCORE_BITS);
         end else begin
            lane_score[k] = clamp_score(lane_score[k] + pair_score(r, c), SCORE_BITS);
            lane_run_closed[k] = 1'b1;
         end
      end
      if (w.last_column) begin
         if (n >= 2) begin
            total = 0;
            for (int k = 0; k < n; k++) total += lane_score[k];
            total = (total * 256) / longint'(n);
         end else begin
            total = bonus_total * 256;
         end
         total = clamp_score(total, OUT_BITS);
         e.block_score = total[OUT_BITS-1:0];
         e.saturated = clip_flag;
         expected_scores = {expected_scores, e};
      end
   endtask

   task automatic send_column(req_type w);
      if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      score_column(w);
      columns_sent++;
   endtask

   // unfilled lanes get an ambiguous base
   function automatic req_type make_column(string s, int count, bit first, bit last);
      req_type w;
      for (int k = 0; k < MAX_LANES; k++)
         w.column_chars[8*k +: 8] = (k < s.len()) ? s[k] : "N";
      w.seq_count = count[COUNT_BITS-1:0];
      w.first_column = first;
      w.last_column = last;
      return w;
   endfunction

   function automatic logic [7:0] pick_char(int gap_pct);
      string bases;
      string iupac;
      int    p;
      bases = "ACGTUacgtu";
      iupac = "NRYMKSWHBVDnrymkswhbvd";
      if ($urandom_range(0, 99) < gap_pct) return "-";
      p = $urandom_range(0, 99);
      if (p < 70) return bases[$urandom_range(0, bases.len() - 1)];
      if (p < 88) return iupac[$urandom_range(0, iupac.len() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic wait_idle;
      req_valid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write a penalty, then read it back
   task automatic write_penalty(logic [0:0] index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (index == REG_GAP_OPEN) open_pen = value[PEN_BITS-1:0];
      else extend_pen = value[PEN_BITS-1:0];
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[PEN_BITS-1:0] !== value[PEN_BITS-1:0]) begin
         $error("penalty readback expected %0d actual %0d",
                value[PEN_BITS-1:0], csr_prdata[PEN_BITS-1:0]);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_penalties(logic [31:0] open_value, logic [31:0] extend_value);
      wait_idle();
      write_penalty(REG_GAP_OPEN, open_value);
      write_penalty(REG_GAP_EXTEND, extend_value);
   endtask

   task automatic test_substitution_pairs;
      send_column(make_column("AACGTN-u", 8, 1, 0));
      send_column(make_column("CACGTx-c", 8, 0, 0));
      send_column(make_column("GACGTr-g", 8, 0, 0));
      send_column(make_column("TACGTy-t", 8, 0, 0));
      // gap on the reference charges every lane
      send_column(make_column("-ACGT-Ng", 8, 0, 0));
      send_column(make_column("NACGT-aN", 8, 0, 1));
   endtask

   task automatic test_gap_runs;
      send_column(make_column("AC-G", 4, 1, 0));
      send_column(make_column("AC-G", 4, 0, 0));
      send_column(make_column("AC--", 4, 0, 0));
      send_column(make_column("ACG-", 4, 0, 0));
      send_column(make_column("-CGT", 4, 0, 1));
   endtask

   task automatic test_single_sequence;
      send_column(make_column("A", 1, 1, 0));
      send_column(make_column("c", 0, 0, 0));
      send_column(make_column("G", 1, 0, 0));
      send_column(make_column("u", 1, 0, 1));
      send_column(make_column("Z", 1, 1, 1));
   endtask

   task automatic test_count_edges;
      req_type w;
      w.column_chars = '1;
      w.seq_count = 4'hF;
      w.first_column = 1'b1;
      w.last_column = 1'b0;
      send_column(w);
      w.column_chars = '0;
      w.seq_count = 4'd8;
      w.first_column = 1'b0;
      send_column(w);
      send_column(make_column("ACGTACGT", 3, 0, 0));
      send_column(make_column("TTTTTTTT", 9, 0, 1));
      // block without a first column carries on from the last one
      send_column(make_column("AAAAAAAA", 2, 0, 0));
      send_column(make_column("CCCCCCCC", 2, 0, 1));
   endtask

   task automatic test_penalty_extremes;
      set_penalties(0, 0);
      send_column(make_column("A-GT-", 5, 1, 0));
      send_column(make_column("--GTA", 5, 0, 1));
      set_penalties(32'h3FF, 32'h3FF);
      send_column(make_column("A-GT-", 5, 1, 0));
      send_column(make_column("--GTA", 5, 0, 1));
      // upper data bits fall outside the register
      set_penalties({$urandom}, {$urandom});
      send_column(make_column("A-GT-", 5, 1, 0));
      send_column(make_column("--GTA", 5, 0, 1));
   endtask

   task automatic send_random_block;
      req_type w;
      int      n;
      int      len;
      int      gap_pct;
      bit      wander;
      bit      carry;
      bit      cut;
      if ($urandom_range(0, 99) < 8) begin
         w.column_chars = {$urandom, $urandom};
         w.seq_count = 4'($urandom_range(0, 15));
         w.first_column = 1'($urandom_range(0, 1));
         w.last_column = 1'($urandom_range(0, 1));
         send_column(w);
         return;
      end
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      gap_pct = $urandom_range(0, 40);
      wander = ($urandom_range(0, 19) == 0);
      carry = ($urandom_range(0, 14) == 0);
      cut = ($urandom_range(0, 19) == 0);
      for (int i = 0; i < len; i++) begin
         for (int k = 0; k < MAX_LANES; k++) w.column_chars[8*k +: 8] = pick_char(gap_pct);
         w.seq_count = wander ? 4'($urandom_range(0, 15)) : 4'(n);
         w.first_column = (i == 0) && !carry;
         w.last_column = (i == len - 1) && !cut;
         send_column(w);
      end
   endtask

   task automatic test_random_blocks;
      int phase_end;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_penalties(32'(GAP_OPEN_RESET), 32'(GAP_EXTEND_RESET));
            1: set_penalties(32'h3FF, 0);
            2: set_penalties(0, 32'h3FF);
            default: set_penalties($urandom_range(0, 1023), $urandom_range(0, 1023));
         endcase
         no_idle = (phase == 2);
         phase_end = columns_sent + RANDOM_ITEMS / 4;
         while (columns_sent < phase_end) send_random_block();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_result_backpressure;
      wait_idle();
      hold_request = 400;
      for (int b = 0; b < 10; b++) begin
         for (int i = 0; i < 3; i++)
            send_column(make_column("ACGT-acg", 8, i == 0, i == 2));
      end
   endtask

   initial begin
      error_count = 0;
      columns_sent = 0;
      no_idle = 1'b0;
      hold_request = 0;
      hold_left = 0;
      for (int k = 0; k < MAX_LANES; k++) begin
         lane_score[k] = 0;
         lane_run_closed[k] = 1'b1;
      end
      bonus_total = 0;
      clip_flag = 1'b0;
      open_pen = GAP_OPEN_RESET;
      extend_pen = GAP_EXTEND_RESET;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      rsp_ready <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_substitution_pairs();
      test_gap_runs();
      test_single_sequence();
      test_count_edges();
      test_penalty_extremes();
      test_random_blocks();
      test_result_backpressure();
      wait_idle();

      if (error_count == 0 && expected_scores.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
